### src/lphm_pkg.sv
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared types and constants of the linear probing hash map: transfer
// payloads, status and mode codes, sequencer states and field widths.
// ----------------------------------------------------------------------------
package lphm_pkg;

	// Default sizing of the table
	localparam int CAPACITY_DEF   = 256;
	localparam int KEY_BITS_DEF   = 64;
	localparam int VALUE_BITS_DEF = 32;

	// Fixed field widths of the ports
	localparam int KEY_W   = 64;
	localparam int HASH_W  = 32;
	localparam int VALUE_W = 32;
	localparam int TOTAL_W = 9;
	localparam int CFG_W   = 9;

	// Table size after reset, and the size taken when zero is written
	localparam int SIZE_RESET    = 2;
	localparam int SIZE_ZERO_SUB = 2;

	// Remainder bits resolved per cycle by the hash reduction unit
	localparam int REM_STEP_BITS = 2;

	typedef enum logic {
		MODE_LOOKUP = 1'b0,
		MODE_PUT    = 1'b1
	} mode_t;

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_MISS     = 3'd1,
		ST_INSERTED = 3'd2,
		ST_UPDATED  = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef struct packed {
		mode_t               mode;
		logic [KEY_W-1:0]    key;
		logic [HASH_W-1:0]   key_hash;
		logic [VALUE_W-1:0]  value_in;
	} item_t;

	typedef struct packed {
		status_t             status;
		logic [VALUE_W-1:0]  value_out;
		logic [TOTAL_W-1:0]  entry_total;
	} result_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_DONE
	} state_t;

endpackage

### src/linear_probe_hash_map.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_map
// Open-addressing hash map with linear probing over a slot RAM with one write
// port and one registered read port.
//
// Each accepted item (lookup or put) passes through these steps in order: the
// remainder unit reduces the 32-bit hash modulo table_size at two bits per
// cycle; the slots are probed in turn from the hashed slot, up to table_size
// of them, through the one registered read port of the slot RAM; the result
// goes to the output register, a hand-over that waits while that register
// still holds an earlier result not yet taken; and the sequencer returns to
// idle, where the next item is taken. One item is in flight at a time; the
// next may be offered while the last result still waits in the output
// register. After reset and after every table_size write a clearing pass
// empties the slots in use; items are held off during it, configuration
// writes are not. Writing table_size starts an empty map; zero selects two
// slots and values above CAPACITY saturate. A put with no free slot reports
// table full and changes nothing.
// ----------------------------------------------------------------------------
module linear_probe_hash_map #(
	parameter int CAPACITY   = lphm_pkg::CAPACITY_DEF,
	parameter int KEY_BITS   = lphm_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = lphm_pkg::VALUE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  lphm_pkg::item_t            item,
	output logic                       result_valid,
	input  logic                       result_ready,
	output lphm_pkg::result_t          result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [lphm_pkg::CFG_W-1:0] cfg_data
);

	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int SIZE_W = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic                  used;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} slot_t;

	// Sequencer and bookkeeping
	lphm_pkg::state_t    state_q, state_n;
	logic [SIZE_W-1:0]   size_q;
	logic [SIZE_W-1:0]   occ_q;
	logic [IDX_W-1:0]    clr_q;
	logic [IDX_W-1:0]    pos_q;
	logic [SIZE_W-1:0]   steps_q;
	lphm_pkg::item_t     item_q;
	lphm_pkg::result_t   res_q;
	lphm_pkg::result_t   result_q;
	logic                result_valid_q;

	// Slot RAM
	slot_t               mem [CAPACITY];
	slot_t               rd_q;
	logic [IDX_W-1:0]    rd_addr;
	logic [IDX_W-1:0]    wr_addr;
	logic                wr_en;
	slot_t               wr_data;

	// Datapath
	logic                cfg_fire;
	logic                item_fire;
	logic [SIZE_W-1:0]   size_new;
	logic                rem_done;
	logic [SIZE_W-1:0]   rem;
	logic [SIZE_W-1:0]   pos_inc;
	logic [IDX_W-1:0]    pos_nxt;
	logic [KEY_BITS-1:0] key_cur;
	logic                hit;
	logic                found;
	logic                probe_last;
	logic                clr_last;
	logic                probe_end;
	logic                occ_inc;
	logic [SIZE_W-1:0]   occ_nxt;
	logic                out_free;
	lphm_pkg::result_t   res_n;

	assign cfg_ready  = (state_q == lphm_pkg::S_CLEAR) || (state_q == lphm_pkg::S_IDLE);
	assign item_ready = (state_q == lphm_pkg::S_IDLE) && !cfg_valid;
	assign cfg_fire   = cfg_valid && cfg_ready;
	assign item_fire  = item_valid && item_ready;
	assign out_free   = !result_valid_q || result_ready;

	// Map the written size: zero selects two slots, saturate at capacity
	always_comb begin
		if (cfg_data == '0) begin
			size_new = SIZE_W'(lphm_pkg::SIZE_ZERO_SUB);
		end else if (32'(cfg_data) > 32'(CAPACITY)) begin
			size_new = SIZE_W'(CAPACITY);
		end else begin
			size_new = SIZE_W'(cfg_data);
		end
	end

	// Hash reduction
	lphm_rem #(
		.SIZE_W (SIZE_W)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (item_fire),
		.dividend (item.key_hash),
		.divisor  (size_q),
		.done     (rem_done),
		.rem      (rem)
	);

	// Probe position, slot compare and end conditions
	assign pos_inc    = SIZE_W'(pos_q) + 1'b1;
	assign pos_nxt    = (pos_inc == size_q) ? '0 : IDX_W'(pos_inc);
	assign key_cur    = KEY_BITS'(item_q.key);
	assign hit        = rd_q.used && (rd_q.key == key_cur);
	assign found      = !rd_q.used || hit;
	assign probe_last = (steps_q == size_q - 1'b1);
	assign clr_last   = (SIZE_W'(clr_q) == size_q - 1'b1);
	assign occ_nxt    = occ_q + SIZE_W'(occ_inc);

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			lphm_pkg::S_CLEAR: begin
				if (!cfg_fire && clr_last) begin
					state_n = lphm_pkg::S_IDLE;
				end
			end
			lphm_pkg::S_IDLE: begin
				if (cfg_fire) begin
					state_n = lphm_pkg::S_CLEAR;
				end else if (item_fire) begin
					state_n = lphm_pkg::S_HASH;
				end
			end
			lphm_pkg::S_HASH: begin
				if (rem_done) begin
					state_n = lphm_pkg::S_PROBE;
				end
			end
			lphm_pkg::S_PROBE: begin
				if (probe_end) begin
					state_n = lphm_pkg::S_DONE;
				end
			end
			lphm_pkg::S_DONE: begin
				if (out_free) begin
					state_n = lphm_pkg::S_IDLE;
				end
			end
			default: state_n = lphm_pkg::S_IDLE;
		endcase
	end

	// Outputs of the sequencer: RAM port control and result decision
	always_comb begin
		rd_addr   = pos_q;
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = '{used: 1'b1, key: key_cur, value: VALUE_BITS'(item_q.value_in)};
		probe_end = 1'b0;
		occ_inc   = 1'b0;
		res_n     = res_q;
		unique case (state_q)
			lphm_pkg::S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			lphm_pkg::S_HASH: begin
				rd_addr = IDX_W'(rem);
			end
			lphm_pkg::S_PROBE: begin
				rd_addr = pos_nxt;
				if (found || probe_last) begin
					probe_end       = 1'b1;
					res_n.value_out = '0;
					if (item_q.mode == lphm_pkg::MODE_LOOKUP) begin
						if (hit) begin
							res_n.status    = lphm_pkg::ST_HIT;
							res_n.value_out = lphm_pkg::VALUE_W'(rd_q.value);
						end else begin
							res_n.status = lphm_pkg::ST_MISS;
						end
					end else if (!found) begin
						res_n.status = lphm_pkg::ST_FULL;
					end else begin
						wr_en = 1'b1;
						if (hit) begin
							res_n.status = lphm_pkg::ST_UPDATED;
						end else begin
							res_n.status = lphm_pkg::ST_INSERTED;
							occ_inc      = 1'b1;
						end
					end
					res_n.entry_total = lphm_pkg::TOTAL_W'(occ_nxt);
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= lphm_pkg::S_CLEAR;
			size_q         <= SIZE_W'(lphm_pkg::SIZE_RESET);
			occ_q          <= '0;
			clr_q          <= '0;
			pos_q          <= '0;
			steps_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			// Start a fresh map on a size write
			if (cfg_fire) begin
				size_q <= size_new;
				occ_q  <= '0;
				clr_q  <= '0;
			end else begin
				occ_q <= occ_nxt;
				if (state_q == lphm_pkg::S_CLEAR) begin
					clr_q <= clr_q + 1'b1;
				end
			end
			// Advance the probe
			if (state_q == lphm_pkg::S_HASH && rem_done) begin
				pos_q   <= IDX_W'(rem);
				steps_q <= '0;
			end else if (state_q == lphm_pkg::S_PROBE && !probe_end) begin
				pos_q   <= pos_nxt;
				steps_q <= steps_q + 1'b1;
			end
			// Hold the result until its transfer
			if (state_q == lphm_pkg::S_DONE && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (item_fire) begin
			item_q <= item;
		end
		if (probe_end) begin
			res_q <= res_n;
		end
		if (state_q == lphm_pkg::S_DONE && out_free) begin
			result_q <= res_q;
		end
	end

	// Slot RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	a_occ_within_size: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= size_q)
		else $error("occupied count exceeds table size");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == lphm_pkg::S_CLEAR || state_q == lphm_pkg::S_PROBE))
		else $error("slot RAM written outside clearing or probing");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lphm_pkg::S_PROBE) |-> (SIZE_W'(pos_q) < size_q))
		else $error("probe position beyond table size");

	a_occ_single_step: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(cfg_fire) && occ_q != $past(occ_q)) |-> (occ_q == $past(occ_q) + 1'b1))
		else $error("occupied count moved by other than one insert");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> ($past(state_q) == lphm_pkg::S_DONE))
		else $error("result presented without a finished item");
`endif

endmodule

### src/lphm_rem.sv
// ----------------------------------------------------------------------------
// lphm_rem
// Iterative remainder unit: reduces the 32-bit key hash modulo the table
// size by restoring division, lphm_pkg::REM_STEP_BITS quotient bits per cycle.
// ----------------------------------------------------------------------------
module lphm_rem #(
	parameter int SIZE_W = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lphm_pkg::HASH_W-1:0] dividend,
	input  logic [SIZE_W-1:0]           divisor,
	output logic                        done,
	output logic [SIZE_W-1:0]           rem
);

	localparam int HW    = lphm_pkg::HASH_W;
	localparam int STEPS = lphm_pkg::HASH_W / lphm_pkg::REM_STEP_BITS;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [HW-1:0]     dvd_q;
	logic [SIZE_W-1:0] rem_q;

	logic [SIZE_W:0]   trial;
	logic [SIZE_W-1:0] rem_n;
	logic [HW-1:0]     dvd_n;

	// Shift in dividend bits, subtract the divisor where it fits
	always_comb begin
		rem_n = rem_q;
		dvd_n = dvd_q;
		trial = '0;
		for (int i = 0; i < lphm_pkg::REM_STEP_BITS; i++) begin
			trial = {rem_n, dvd_n[HW-1]};
			if (trial >= {1'b0, divisor}) begin
				trial = trial - {1'b0, divisor};
			end
			rem_n = trial[SIZE_W-1:0];
			dvd_n = {dvd_n[HW-2:0], 1'b0};
		end
	end

	// Step counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(STEPS);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	// Partial remainder and remaining dividend bits
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			dvd_q <= dvd_n;
			rem_q <= rem_n;
		end
	end

	assign done = busy_q && (cnt_q == '0);
	assign rem  = rem_q;

endmodule

### dv/hash_map_checker.sv
// ----------------------------------------------------------------------------
// hash_map_checker
// Watches the item, result and table-size channels of the hash map, keeps its
// own copy of the slot table, works out the result of every accepted item and
// compares each result transfer, field by field, against the oldest one due.
// ----------------------------------------------------------------------------
module hash_map_checker
	import lphm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_ready,
	input  item_t             item,
	input  logic              result_valid,
	input  logic              result_ready,
	input  result_t           result,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data,
	output int                mismatch_count,
	output int                pending_count,
	output int                results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = CAPACITY_DEF;

	// Shadow of the slot table
	bit                 slot_full [SLOTS];
	logic [KEY_W-1:0]   slot_key  [SLOTS];
	logic [VALUE_W-1:0] slot_val  [SLOTS];
	int unsigned        occupied;
	int unsigned        slots_in_use;

	// Running totals handed to the top
	int mismatches = 0;
	int pending    = 0;
	int checked    = 0;

	// Results still due from the block, oldest first
	result_t awaited_results[$];

	assign mismatch_count  = mismatches;
	assign pending_count   = pending;
	assign results_checked = checked;

	// Empty every slot
	task automatic clear_table();
		int i;
		for (i = 0; i < SLOTS; i++)
			slot_full[i] = 1'b0;
		occupied = 0;
	endtask

	// Take a new table size: zero means two, oversize saturates, map restarts
	task automatic load_table_size(input logic [CFG_W-1:0] req);
		int unsigned n;
		n = req;
		if (n == 0)
			n = SIZE_ZERO_SUB;
		if (n > SLOTS)
			n = SLOTS;
		slots_in_use = n;
		clear_table();
	endtask

	// Probe from the hashed slot, update the shadow and give the result due
	task automatic apply_map_item(input item_t it, output result_t r);
		int unsigned pos;
		int unsigned step;
		int          found;
		found = -1;
		pos   = it.key_hash % slots_in_use;
		for (step = 0; step < slots_in_use && found < 0; step++) begin
			if (!slot_full[pos] || slot_key[pos] == it.key)
				found = pos;
			else
				pos = (pos + 1 >= slots_in_use) ? 0 : pos + 1;
		end
		r.value_out = '0;
		if (it.mode == MODE_LOOKUP) begin
			if (found >= 0 && slot_full[found]) begin
				r.status    = ST_HIT;
				r.value_out = slot_val[found];
			end else begin
				r.status = ST_MISS;
			end
		end else if (found < 0) begin
			r.status = ST_FULL;
		end else if (slot_full[found]) begin
			slot_val[found] = it.value_in;
			r.status        = ST_UPDATED;
		end else begin
			slot_full[found] = 1'b1;
			slot_key[found]  = it.key;
			slot_val[found]  = it.value_in;
			occupied++;
			r.status = ST_INSERTED;
		end
		r.entry_total = occupied[TOTAL_W-1:0];
	endtask

	// Follow every transfer at the rising edge
	always @(posedge clk or negedge arst_n) begin
		result_t due;
		result_t got;
		if (!arst_n) begin
			clear_table();
			slots_in_use = SIZE_RESET;
			awaited_results.delete();
		end else begin
			if (result_valid && result_ready) begin
				got = result;
				checked++;
				if (awaited_results.size() == 0) begin
					$error("result transfer with no result due: status %0d value_out %0h",
						got.status, got.value_out);
					mismatches++;
				end else begin
					due = awaited_results.pop_front();
					if (got.status !== due.status) begin
						$error("status: expected %0d, actual %0d", due.status, got.status);
						mismatches++;
					end
					if (got.value_out !== due.value_out) begin
						$error("value_out: expected %0h, actual %0h",
							due.value_out, got.value_out);
						mismatches++;
					end
					if (got.entry_total !== due.entry_total) begin
						$error("entry_total: expected %0d, actual %0d",
							due.entry_total, got.entry_total);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				load_table_size(cfg_data);
			if (item_valid && item_ready) begin
				apply_map_item(item, due);
				awaited_results.push_back(due);
			end
		end
		pending = awaited_results.size();
	end

endmodule

### dv/linear_probe_hash_map_tb.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_map_tb
// Drives lookups and puts into the hash map under a series of table sizes,
// from one slot to the saturated maximum, with random gaps on both channels
// and one long result back-pressure stretch; the checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module linear_probe_hash_map_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lphm_pkg::*;

	localparam int LONG_HOLD   = 600;
	localparam int DRAIN_LIMIT = 20000;
	localparam int TAIL_CYCLES = 300;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	item_t            item;
	logic             result_valid;
	logic             result_ready;
	result_t          result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	int mismatch_count;
	int pending_count;
	int results_checked;

	bit idle_enable   = 1'b1;
	bit long_hold_req = 1'b0;
	int items_sent    = 0;
	int size_writes   = 0;

	logic [KEY_W-1:0]  pool_key  [64];
	logic [HASH_W-1:0] pool_hash [64];

	linear_probe_hash_map DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	hash_map_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.item            (item),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.result          (result),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.pending_count   (pending_count),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Give up long after the slowest correct run
	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

	// Drain results, with random stalls and one long hold when asked
	initial begin : result_sink
		int stall_left;
		stall_left   = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && arst_n) begin
				if (long_hold_req) begin
					stall_left    = LONG_HOLD;
					long_hold_req = 1'b0;
				end else if (idle_enable && $urandom_range(0, 9) == 0) begin
					stall_left = $urandom_range(1, 19);
				end
			end
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= arst_n;
			end
		end
	end

	// Offer one item, perhaps after a gap, and hold it until transferred
	task automatic send_item(input mode_t m, input logic [KEY_W-1:0] k,
			input logic [HASH_W-1:0] h, input logic [VALUE_W-1:0] v);
		item_t it;
		int    gap;
		it.mode     = m;
		it.key      = k;
		it.key_hash = h;
		it.value_in = v;
		@(negedge clk);
		if (idle_enable && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 19);
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (!item_ready);
		items_sent++;
	endtask

	// Drop valid and wait until every result due has arrived
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
	endtask

	// Write table_size while the block is idle
	task automatic write_table_size(input logic [CFG_W-1:0] v);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		size_writes++;
	endtask

	// Random traffic over a pool of keys, some sharing a hash, plus noise
	task automatic random_phase(input logic [CFG_W-1:0] size_req, input int pool_n,
			input int n_items, input bit with_hold);
		int                 i;
		int                 idx;
		logic [KEY_W-1:0]   k;
		logic [HASH_W-1:0]  h;
		logic [VALUE_W-1:0] v;
		mode_t              m;
		write_table_size(size_req);
		for (i = 0; i < pool_n; i++) begin
			pool_key[i]  = {$urandom, $urandom};
			pool_hash[i] = (i > 0 && $urandom_range(0, 9) < 3) ? pool_hash[i-1] : $urandom;
		end
		for (i = 0; i < n_items; i++) begin
			if (with_hold && i == n_items / 3)
				long_hold_req = 1'b1;
			if ($urandom_range(0, 99) < 85) begin
				idx = $urandom_range(0, pool_n - 1);
				k   = pool_key[idx];
				h   = pool_hash[idx];
			end else begin
				k = {$urandom, $urandom};
				h = $urandom;
			end
			m = ($urandom_range(0, 99) < 55) ? MODE_PUT : MODE_LOOKUP;
			case ($urandom_range(0, 9))
				0:       v = '0;
				1:       v = '1;
				default: v = $urandom;
			endcase
			send_item(m, k, h, v);
		end
	endtask

	initial begin : stimulus
		int drain;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Two slots after reset: miss, insert, hit on zero, update, full
		send_item(MODE_LOOKUP, '0, '0, '0);
		send_item(MODE_PUT, '0, '0, '0);
		send_item(MODE_LOOKUP, '0, '0, $urandom);
		send_item(MODE_PUT, '1, '1, '1);
		send_item(MODE_PUT, '0, '0, '1);
		send_item(MODE_PUT, 64'h5, '0, $urandom);
		send_item(MODE_LOOKUP, 64'h5, 32'h7, '0);
		send_item(MODE_LOOKUP, '1, '1, '0);

		// Zero selects two slots and empties the map
		write_table_size('0);
		send_item(MODE_LOOKUP, '1, '1, '0);

		// One slot
		write_table_size(9'd1);
		send_item(MODE_PUT, 64'h0123_4567_89ab_cdef, $urandom, $urandom);
		send_item(MODE_PUT, 64'hfedc_ba98_7654_3210, $urandom, $urandom);
		send_item(MODE_LOOKUP, 64'h0123_4567_89ab_cdef, $urandom, '0);
		send_item(MODE_LOOKUP, 64'hfedc_ba98_7654_3210, $urandom, '0);

		// Oversize saturates; probe across the wrap from the last slot
		write_table_size(9'd300);
		send_item(MODE_PUT, 64'hc0, 32'd255, $urandom);
		send_item(MODE_PUT, 64'hd0, 32'd255, $urandom);
		send_item(MODE_PUT, 64'he0, 32'd0, $urandom);
		send_item(MODE_LOOKUP, 64'hd0, 32'd255, '0);
		send_item(MODE_LOOKUP, 64'he0, 32'd0, '0);
		send_item(MODE_LOOKUP, 64'hf0, 32'd255, '0);
		send_item(MODE_PUT, 64'hd0, 32'd255, $urandom);

		// Random phases over several sizes
		random_phase(9'd5, 8, 60, 1'b0);
		random_phase(9'd3, 5, 50, 1'b0);
		random_phase(9'd16, 24, 70, 1'b1);
		random_phase(9'd511, 40, 50, 1'b0);
		random_phase(9'd1, 2, 20, 1'b0);
		random_phase(9'd64, 48, 60, 1'b0);
		random_phase(9'd256, 48, 40, 1'b0);
		idle_enable = 1'b0;
		random_phase(9'd7, 10, 50, 1'b0);

		// Wait for the last results, then for the block to go quiet
		@(negedge clk);
		item_valid <= 1'b0;
		drain = 0;
		while (pending_count != 0 && drain < DRAIN_LIMIT) begin
			@(negedge clk);
			drain++;
		end
		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending_count != 0)
			$error("%0d results never arrived", pending_count);

		$display("Covered %0d lookups and puts under %0d table size writes (1 to 256 slots),",
			items_sent, size_writes);
		$display("with %0d results checked, including full tables and wrapped probes",
			results_checked);
		if (mismatch_count == 0 && pending_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
